FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tce_pkg.sv
package tce_pkg;

	localparam int DATA_W = 8;
	localparam int REG_N  = 4;
	localparam int RIDX_W = $clog2(REG_N);
	localparam int CNT_W  = $clog2(DATA_W);

	// immediate loads always target D
	localparam logic [RIDX_W-1:0] IMM_DST = RIDX_W'(REG_N - 1);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_IN  = 3'd4,
		OP_OUT = 3'd5
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_ctl_t;

endpackage

FILE: src/tce_alu.sv
`include "assert_macros.svh"

// Bit-serial ALU: one bit of the result per cycle.
module tce_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tce_pkg::alu_ctl_t             ctl,
	input  logic [tce_pkg::DATA_W-1:0]    a,
	input  logic [tce_pkg::DATA_W-1:0]    b,
	output logic                          done,
	output logic [tce_pkg::DATA_W-1:0]    result
);

	localparam int W = tce_pkg::DATA_W;
	localparam logic [tce_pkg::CNT_W-1:0] LAST = tce_pkg::CNT_W'(W - 1);

	tce_pkg::op_t              op_q;
	logic                      busy_q;
	logic                      done_q;
	logic [tce_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]              a_q;
	logic [W-1:0]              b_q;
	logic [W-1:0]              acc_q;
	logic                      carry_q;

	logic         is_sub;
	logic         bb;
	logic         sum_bit;
	logic         carry_nxt;
	logic [W-1:0] mul_nxt;
	logic [W+1:0] div_diff;
	logic         borrow;

	always_comb begin
		is_sub    = (op_q == tce_pkg::OP_SUB);
		bb        = b_q[0] ^ is_sub;
		sum_bit   = a_q[0] ^ bb ^ carry_q;
		carry_nxt = (a_q[0] & bb) | (a_q[0] & carry_q) | (bb & carry_q);
		// MSB-first shift and add, wraps at W bits
		mul_nxt   = {acc_q[W-2:0], 1'b0} + (b_q[W-1] ? a_q : {W{1'b0}});
		// restoring divide: partial remainder stays below the divisor
		div_diff  = {1'b0, acc_q, a_q[W-1]} - {2'b00, b_q};
		borrow    = div_diff[W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= tce_pkg::OP_ADD;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
			carry_q <= 1'b0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == LAST);
			if (ctl.start) begin
				op_q    <= ctl.op;
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				a_q     <= a;
				b_q     <= b;
				acc_q   <= '0;
				carry_q <= (ctl.op == tce_pkg::OP_SUB);
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= (cnt_q != LAST);
				case (op_q)
					tce_pkg::OP_ADD, tce_pkg::OP_SUB: begin
						a_q     <= {1'b0, a_q[W-1:1]};
						b_q     <= {1'b0, b_q[W-1:1]};
						acc_q   <= {sum_bit, acc_q[W-1:1]};
						carry_q <= carry_nxt;
					end
					tce_pkg::OP_MUL: begin
						b_q   <= {b_q[W-2:0], 1'b0};
						acc_q <= mul_nxt;
					end
					tce_pkg::OP_DIV: begin
						a_q   <= {a_q[W-2:0], ~borrow};
						acc_q <= borrow ? {acc_q[W-2:0], a_q[W-1]} : div_diff[W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == tce_pkg::OP_DIV) ? a_q : acc_q;

	`ASSERT_IMPL(a_no_restart, clk, arst_n, ctl.start, !busy_q, "ALU started while busy")
	`ASSERT_IMPL(a_done_after_last, clk, arst_n, done_q, $past(busy_q && cnt_q == LAST), "ALU done without final step")
	`ASSERT_NEXT(a_last_step, clk, arst_n, busy_q && !ctl.start && cnt_q == LAST, done_q && !busy_q, "ALU did not finish after final step")

endmodule

FILE: src/tiny_cpu_instruction_executor.sv
// Four-register 8-bit instruction executor.
// Input channel: instr and in_value qualified by in_valid; the block holds in_stall
// high while an instruction is in flight. One transaction is taken per edge with
// in_valid high and in_stall low.
// Result channel: out_valid, out_value and reg_a..reg_d qualified by res_valid,
// held stable while res_stall is high. Exactly one result per instruction.
// Immediate loads, IN, OUT, unused opcodes and a divide by zero go from the
// input straight to write-back; ADD, SUB, MUL and DIV first run through the
// bit-serial ALU one bit per cycle, then the block sees done and writes back.
// The next instruction can be taken while the previous result waits in the
// output register; its write-back waits until that result is taken, so a
// stalled receiver holds at most one finished result and one pending one.
// Reset clears all four registers to zero and empties the output register.
`include "assert_macros.svh"

module tiny_cpu_instruction_executor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tce_pkg::DATA_W-1:0] instr,
	input  logic [tce_pkg::DATA_W-1:0] in_value,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       out_valid,
	output logic [tce_pkg::DATA_W-1:0] out_value,
	output logic [tce_pkg::DATA_W-1:0] reg_a,
	output logic [tce_pkg::DATA_W-1:0] reg_b,
	output logic [tce_pkg::DATA_W-1:0] reg_c,
	output logic [tce_pkg::DATA_W-1:0] reg_d
);

	localparam int W  = tce_pkg::DATA_W;
	localparam int RW = tce_pkg::RIDX_W;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WB} state_t;

	state_t          state_q;
	logic [W-1:0]    rf_q [tce_pkg::REG_N];
	logic [RW-1:0]   dst_q;
	logic            wb_en_q;
	logic            use_alu_q;
	logic [W-1:0]    wb_val_q;
	logic            flag_q;
	logic [W-1:0]    emit_q;
	logic            res_valid_q;
	logic            out_valid_q;
	logic [W-1:0]    out_value_q;

	logic              acc_in;
	logic              is_imm;
	tce_pkg::op_t      opc;
	logic [RW-1:0]     dst;
	logic [RW-1:0]     src;
	logic [W-1:0]      dv;
	logic [W-1:0]      sv;
	logic              zero_div;
	logic              alu_op;
	logic              out_free;
	tce_pkg::alu_ctl_t alu_ctl;
	logic              alu_done;
	logic [W-1:0]      alu_result;

	always_comb begin
		acc_in   = in_valid && !in_stall;
		is_imm   = !instr[W-1];
		opc      = tce_pkg::op_t'(instr[6:4]);
		dst      = instr[3:2];
		src      = instr[1:0];
		dv       = rf_q[dst];
		sv       = rf_q[src];
		zero_div = (opc == tce_pkg::OP_DIV) && (sv == '0);
		// divide by zero skips the ALU and leaves the destination alone
		alu_op   = !is_imm && !zero_div &&
			(opc == tce_pkg::OP_ADD || opc == tce_pkg::OP_SUB ||
			 opc == tce_pkg::OP_MUL || opc == tce_pkg::OP_DIV);
		out_free = !res_valid_q || !res_stall;
		alu_ctl.start = acc_in && alu_op;
		alu_ctl.op    = opc;
	end

	tce_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (dv),
		.b      (sv),
		.done   (alu_done),
		.result (alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < tce_pkg::REG_N; i++) begin
				rf_q[i] <= '0;
			end
			dst_q       <= '0;
			wb_en_q     <= 1'b0;
			use_alu_q   <= 1'b0;
			wb_val_q    <= '0;
			flag_q      <= 1'b0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (state_q == ST_WB && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (is_imm) begin
							dst_q     <= tce_pkg::IMM_DST;
							wb_en_q   <= 1'b1;
							use_alu_q <= 1'b0;
							wb_val_q  <= {1'b0, instr[W-2:0]};
							flag_q    <= 1'b0;
							emit_q    <= '0;
							state_q   <= ST_WB;
						end else begin
							dst_q     <= dst;
							wb_en_q   <= alu_op || (opc == tce_pkg::OP_IN);
							use_alu_q <= alu_op;
							wb_val_q  <= in_value;
							flag_q    <= (opc == tce_pkg::OP_OUT);
							emit_q    <= (opc == tce_pkg::OP_OUT) ? sv : '0;
							state_q   <= alu_op ? ST_EXEC : ST_WB;
						end
					end
				end
				ST_EXEC: begin
					if (alu_done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (out_free) begin
						if (wb_en_q) begin
							rf_q[dst_q] <= use_alu_q ? alu_result : wb_val_q;
						end
						out_valid_q <= flag_q;
						out_value_q <= emit_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign reg_a     = rf_q[0];
	assign reg_b     = rf_q[1];
	assign reg_c     = rf_q[2];
	assign reg_d     = rf_q[3];

	`ASSERT_IMPL(a_done_in_exec, clk, arst_n, alu_done, state_q == ST_EXEC, "ALU finished outside execute")
	`ASSERT_NEXT(a_alu_start, clk, arst_n, alu_ctl.start, state_q == ST_EXEC, "ALU op accepted without entering execute")
	`ASSERT_NEXT(a_wb_lands, clk, arst_n, state_q == ST_WB && !res_valid_q, res_valid_q && state_q == ST_IDLE, "write-back did not produce a result")
	`ASSERT_IMPL(a_out_quiet, clk, arst_n, res_valid_q && !out_valid_q, out_value_q == '0, "out_value set without OUT")

endmodule
